// ===== rtl/gmea_pkg.sv =====
`timescale 1ns / 1ps

package gmea_pkg;

    localparam int DvdW  = 48;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_MUL   = 3'd2;
    localparam logic [2:0] MODE_DIV   = 3'd3;
    localparam logic [2:0] MODE_COPY  = 3'd4;
    localparam logic [2:0] MODE_BELOW = 3'd5;
    localparam logic [2:0] MODE_ABOVE = 3'd6;
    localparam logic [2:0] MODE_MATCH = 3'd7;

    localparam logic [1:0] REG_OP_MODE   = 2'd0;
    localparam logic [1:0] REG_OFFSET    = 2'd1;
    localparam logic [1:0] REG_TOLERANCE = 2'd2;
    localparam logic [1:0] REG_UNDEF     = 2'd3;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] a_alt;
        logic        sat_alt;
        logic        is_div;
        logic        div_zero;
        logic        neg_q;
        logic [31:0] b_eff;
        logic        set_undef;
        logic        last;
    } side_t;

    // Bit 32 is the clip flag, bits 31:0 the clipped value.
    function automatic logic [32:0] clip33(input logic [32:0] v);
        logic [32:0] r;
        begin
            if (v[32] != v[31])
            begin
                r = {1'b1, (v[32] ? Q_MIN : Q_MAX)};
            end
            else
            begin
                r = {1'b0, v[31:0]};
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/gmea_prep.sv =====
`timescale 1ns / 1ps

module gmea_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vld_in,
    input  logic [31:0]        a_value,
    input  logic [31:0]        b_value,
    input  logic               last_in,
    input  logic [2:0]         op_mode,
    input  logic [31:0]        offset_factor,
    input  logic [30:0]        tolerance,
    input  logic [31:0]        undefined_code,
    output logic               vld_out,
    output logic [31:0]        dvd_mag,
    output logic [31:0]        dsr_mag,
    output gmea_pkg::side_t    side
);

    logic        p1_vld_reg;
    logic        run_reg;
    logic [2:0]  mode_reg;
    logic [31:0] a_reg;
    logic [31:0] beff_reg;
    logic [32:0] sum_reg;
    logic        hit_reg;
    logic [63:0] prod_reg;
    logic [31:0] amag_reg;
    logic [31:0] bmag_reg;
    logic        is_div_reg;
    logic        div_zero_reg;
    logic        neg_reg;
    logic        undef_reg;
    logic        last_reg;

    logic        p2_vld_reg;
    logic [31:0] dvd_reg;
    logic [31:0] dsr_reg;
    gmea_pkg::side_t side_reg;

    logic               run;
    logic               guard;
    logic [31:0]        bmag;
    logic [31:0]        amag;
    logic [31:0]        b_eff;
    logic signed [33:0] a34;
    logic signed [33:0] b34;
    logic signed [33:0] f34;
    logic signed [33:0] t34;
    logic [32:0]        sum_next;
    logic               hit_next;
    logic [63:0]        prod_next;

    always_comb
    begin
        run   = (a_value != undefined_code) && (b_value != undefined_code);
        bmag  = b_value[31] ? (~b_value + 32'd1) : b_value;
        amag  = a_value[31] ? (~a_value + 32'd1) : a_value;
        guard = run && (op_mode == gmea_pkg::MODE_DIV) && (bmag < {1'b0, tolerance});
        b_eff = guard ? {1'b0, tolerance} : b_value;
        a34   = {{2{a_value[31]}}, a_value};
        b34   = {{2{b_value[31]}}, b_value};
        f34   = {{2{offset_factor[31]}}, offset_factor};
        t34   = {3'b000, tolerance};
        prod_next = $signed(a_value) * $signed(b_value);
        sum_next  = 33'(a34 + b34);
        hit_next  = 1'b1;
        case (op_mode)
            gmea_pkg::MODE_SUB:
            begin
                sum_next = 33'(a34 - b34);
            end
            gmea_pkg::MODE_BELOW:
            begin
                sum_next = 33'(b34 + f34);
                hit_next = (a34 - f34) <= (b34 - t34);
            end
            gmea_pkg::MODE_ABOVE:
            begin
                sum_next = 33'(b34 - f34);
                hit_next = (a34 + f34) >= (b34 + t34);
            end
            gmea_pkg::MODE_MATCH:
            begin
                hit_next = (b34 > (f34 - t34)) && (b34 <= (f34 + t34));
            end
            default:
            begin
                sum_next = 33'(a34 + b34);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= vld_in;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            run_reg      <= run;
            mode_reg     <= op_mode;
            a_reg        <= a_value;
            beff_reg     <= b_eff;
            sum_reg      <= sum_next;
            hit_reg      <= hit_next;
            prod_reg     <= prod_next;
            amag_reg     <= amag;
            bmag_reg     <= guard ? {1'b0, tolerance} : bmag;
            is_div_reg   <= run && (op_mode == gmea_pkg::MODE_DIV);
            div_zero_reg <= (b_eff == 32'd0);
            neg_reg      <= a_value[31] ^ b_eff[31];
            undef_reg    <= (b_eff == undefined_code);
            last_reg     <= last_in;
        end
    end

    logic [63:0]     rnd;
    logic [32:0]     clip_sum;
    gmea_pkg::side_t side_next;

    always_comb
    begin
        rnd      = prod_reg + 64'd32768;
        clip_sum = gmea_pkg::clip33(sum_reg);
        side_next.a_alt     = a_reg;
        side_next.sat_alt   = 1'b0;
        side_next.is_div    = is_div_reg;
        side_next.div_zero  = div_zero_reg;
        side_next.neg_q     = neg_reg;
        side_next.b_eff     = beff_reg;
        side_next.set_undef = undef_reg;
        side_next.last      = last_reg;
        if (run_reg)
        begin
            case (mode_reg)
                gmea_pkg::MODE_MUL:
                begin
                    if ((&rnd[63:47]) || !(|rnd[63:47]))
                    begin
                        side_next.a_alt = rnd[47:16];
                    end
                    else
                    begin
                        side_next.a_alt   = rnd[63] ? gmea_pkg::Q_MIN : gmea_pkg::Q_MAX;
                        side_next.sat_alt = 1'b1;
                    end
                end
                gmea_pkg::MODE_COPY:
                begin
                    side_next.a_alt = beff_reg;
                end
                gmea_pkg::MODE_MATCH:
                begin
                    if (hit_reg)
                    begin
                        side_next.a_alt = beff_reg;
                    end
                end
                gmea_pkg::MODE_DIV:
                begin
                    side_next.a_alt = a_reg;
                end
                default:
                begin
                    if (hit_reg)
                    begin
                        side_next.a_alt   = clip_sum[31:0];
                        side_next.sat_alt = clip_sum[32];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg  <= amag_reg;
            dsr_reg  <= bmag_reg;
            side_reg <= side_next;
        end
    end

    assign vld_out = p2_vld_reg;
    assign dvd_mag = dvd_reg;
    assign dsr_mag = dsr_reg;
    assign side    = side_reg;

endmodule

// ===== rtl/gmea_div.sv =====
`timescale 1ns / 1ps

module gmea_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  logic [31:0]     dvd_mag,
    input  logic [31:0]     dsr_mag,
    input  gmea_pkg::side_t side_in,
    output logic            vld_out,
    output logic [47:0]     quo,
    output gmea_pkg::side_t side_out
);

    localparam int N = gmea_pkg::DvdW;

    logic [N-1:0]    vld_reg;
    logic [31:0]     rem_reg  [N];
    logic [N-1:0]    dvd_reg  [N];
    logic [N-1:0]    quo_reg  [N];
    logic [31:0]     dsr_reg  [N];
    gmea_pkg::side_t side_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [31:0]     rem_prev;
            logic [N-1:0]    dvd_prev;
            logic [N-1:0]    quo_prev;
            logic [31:0]     dsr_prev;
            gmea_pkg::side_t side_prev;
            logic            vld_prev;
            logic [32:0]     trial;
            logic            ge;

            if (k == 0)
            begin : g_first
                assign rem_prev  = 32'd0;
                assign dvd_prev  = {dvd_mag, 16'd0};
                assign quo_prev  = '0;
                assign dsr_prev  = dsr_mag;
                assign side_prev = side_in;
                assign vld_prev  = vld_in;
            end
            else
            begin : g_next
                assign rem_prev  = rem_reg[k-1];
                assign dvd_prev  = dvd_reg[k-1];
                assign quo_prev  = quo_reg[k-1];
                assign dsr_prev  = dsr_reg[k-1];
                assign side_prev = side_reg[k-1];
                assign vld_prev  = vld_reg[k-1];
            end

            assign trial = {rem_prev, dvd_prev[N-1]};
            assign ge    = trial >= {1'b0, dsr_prev};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? 32'(trial - {1'b0, dsr_prev}) : trial[31:0];
                    dvd_reg[k]  <= {dvd_prev[N-2:0], 1'b0};
                    quo_reg[k]  <= {quo_prev[N-2:0], ge};
                    dsr_reg[k]  <= dsr_prev;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign vld_out  = vld_reg[N-1];
    assign quo      = quo_reg[N-1];
    assign side_out = side_reg[N-1];

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[N-1] && (dsr_reg[N-1] != 32'd0)) |-> (rem_reg[N-1] < dsr_reg[N-1]))
        else $error("divider remainder not below divisor");

    a_stall_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("divider valid bits moved during stall");

endmodule

// ===== rtl/gmea_post.sv =====
`timescale 1ns / 1ps

module gmea_post (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  logic [47:0]     quo,
    input  gmea_pkg::side_t side,
    input  logic [31:0]     undefined_code,
    output logic            vld_out,
    output logic [31:0]     a_out,
    output logic [31:0]     b_out,
    output logic            sat_out,
    output logic            last_out
);

    logic        vld_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic        sat_reg;
    logic        last_reg;

    logic [31:0] a_next;
    logic        sat_next;

    always_comb
    begin
        a_next   = side.a_alt;
        sat_next = side.sat_alt;
        if (side.is_div)
        begin
            if (side.div_zero)
            begin
                a_next   = side.neg_q ? gmea_pkg::Q_MIN : gmea_pkg::Q_MAX;
                sat_next = 1'b1;
            end
            else if (side.neg_q)
            begin
                if ((|quo[47:32]) || (quo[31] && (|quo[30:0])))
                begin
                    a_next   = gmea_pkg::Q_MIN;
                    sat_next = 1'b1;
                end
                else
                begin
                    a_next = ~quo[31:0] + 32'd1;
                end
            end
            else
            begin
                if (|quo[47:31])
                begin
                    a_next   = gmea_pkg::Q_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    a_next = quo[31:0];
                end
            end
        end
        if (side.set_undef)
        begin
            a_next = undefined_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= side.b_eff;
            sat_reg  <= sat_next;
            last_reg <= side.last;
        end
    end

    assign vld_out  = vld_reg;
    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign sat_out  = sat_reg;
    assign last_out = last_reg;

endmodule

// ===== rtl/grid_map_elementwise_alu_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid / in_ready       a_value, b_value, last_in
// output    out_valid / out_ready     a_result, b_result, saturated, last_out
// config    cfg_we                    cfg_index, cfg_data
//
// Every transaction passes 51 register stages: two operand stages, one stage per
// quotient bit of the 48-bit divider, and the output register. The first stage
// loads at the accepting edge. One transaction is accepted per cycle while the
// output is free or taken. Reset clears all valid bits and loads the register
// defaults. A stalled output freezes the whole pipeline, so in_ready is low
// exactly while out_valid is high and out_ready is low.

module grid_map_elementwise_alu_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] a_value,
    input  logic [31:0] b_value,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] a_result,
    output logic [31:0] b_result,
    output logic        saturated,
    output logic        last_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [2:0]  op_mode_reg;
    logic [31:0] offset_reg;
    logic [30:0] tolerance_reg;
    logic [31:0] undef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg   <= gmea_pkg::MODE_ADD;
            offset_reg    <= 32'd0;
            tolerance_reg <= 31'd1;
            undef_reg     <= gmea_pkg::Q_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gmea_pkg::REG_OP_MODE:   op_mode_reg   <= cfg_data[2:0];
                gmea_pkg::REG_OFFSET:    offset_reg    <= cfg_data;
                gmea_pkg::REG_TOLERANCE: tolerance_reg <= cfg_data[30:0];
                gmea_pkg::REG_UNDEF:     undef_reg     <= cfg_data;
                default:                 op_mode_reg   <= op_mode_reg;
            endcase
        end
    end

    logic            en;
    logic            prep_vld;
    logic [31:0]     dvd_mag;
    logic [31:0]     dsr_mag;
    gmea_pkg::side_t prep_side;
    logic            div_vld;
    logic [47:0]     quo;
    gmea_pkg::side_t div_side;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    gmea_prep u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .vld_in         (in_valid),
        .a_value        (a_value),
        .b_value        (b_value),
        .last_in        (last_in),
        .op_mode        (op_mode_reg),
        .offset_factor  (offset_reg),
        .tolerance      (tolerance_reg),
        .undefined_code (undef_reg),
        .vld_out        (prep_vld),
        .dvd_mag        (dvd_mag),
        .dsr_mag        (dsr_mag),
        .side           (prep_side)
    );

    gmea_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (prep_vld),
        .dvd_mag  (dvd_mag),
        .dsr_mag  (dsr_mag),
        .side_in  (prep_side),
        .vld_out  (div_vld),
        .quo      (quo),
        .side_out (div_side)
    );

    gmea_post u_post (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .vld_in         (div_vld),
        .quo            (quo),
        .side           (div_side),
        .undefined_code (undef_reg),
        .vld_out        (out_valid),
        .a_out          (a_result),
        .b_out          (b_result),
        .sat_out        (saturated),
        .last_out       (last_out)
    );

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> u_prep.p1_vld_reg)
        else $error("accepted transaction did not enter the pipeline");

    a_stall_freezes_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(a_result) && $stable(saturated)))
        else $error("output changed while stalled");

endmodule
